/* rtl/core/iuct_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// iuct_pkg: shared types and constants for the interval union coverage table
// Holds the default sizes, the operation codes, the sequencer states and the
// control structs passed between the table store, compare unit and top level.
// ----------------------------------------------------------------------------
package iuct_pkg;

  localparam int MAX_INTERVALS_DEF = 64;
  localparam int COORD_BITS_DEF    = 32;
  localparam int FIELD_BITS        = 32;

  typedef enum logic [0:0] {
    FUNC_ADD   = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MERGE,
    ST_WRITE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } store_cmd_t;

  typedef struct packed {
    logic contain;
    logic overlap;
  } cmp_res_t;

endpackage
`default_nettype wire

/* rtl/core/iuct_cmp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// iuct_cmp: interval compare unit
// Checks one stored interval against the item for containment and overlap,
// and folds it into the running merged interval.
// ----------------------------------------------------------------------------
module iuct_cmp #(
  parameter int COORD_BITS = iuct_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0] item_low,
  input  logic [COORD_BITS-1:0] item_high,
  input  logic [COORD_BITS-1:0] entry_low,
  input  logic [COORD_BITS-1:0] entry_high,
  input  logic [COORD_BITS-1:0] acc_low,
  input  logic [COORD_BITS-1:0] acc_high,
  output iuct_pkg::cmp_res_t    res,
  output logic [COORD_BITS-1:0] merge_low,
  output logic [COORD_BITS-1:0] merge_high
);

  assign res.contain = (entry_low <= item_low) && (item_high <= entry_high);
  // a shared endpoint counts as overlap
  assign res.overlap = (entry_low <= item_high) && (item_low <= entry_high);

  assign merge_low  = (entry_low < acc_low) ? entry_low : acc_low;
  assign merge_high = (entry_high > acc_high) ? entry_high : acc_high;

endmodule
`default_nettype wire

/* rtl/core/iuct_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// iuct_store: interval table storage
// Endpoint memory with one registered read port and one write port, plus a
// valid bit per entry that reset clears.
// ----------------------------------------------------------------------------
module iuct_store #(
  parameter int MAX_INTERVALS = iuct_pkg::MAX_INTERVALS_DEF,
  parameter int COORD_BITS    = iuct_pkg::COORD_BITS_DEF,
  localparam int IDX_W        = $clog2(MAX_INTERVALS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  iuct_pkg::store_cmd_t  cmd,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic [COORD_BITS-1:0] rd_low,
  output logic [COORD_BITS-1:0] rd_high,
  output logic                  rd_valid,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [COORD_BITS-1:0] wr_low,
  input  logic [COORD_BITS-1:0] wr_high,
  input  logic [IDX_W-1:0]      clr_addr
);

  logic [COORD_BITS-1:0]    mem_low  [MAX_INTERVALS];
  logic [COORD_BITS-1:0]    mem_high [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] valid;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_low[wr_addr]  <= wr_low;
      mem_high[wr_addr] <= wr_high;
    end
    if (cmd.rd_en) begin
      rd_low   <= mem_low[rd_addr];
      rd_high  <= mem_high[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (cmd.clr_en) begin
        valid[clr_addr] <= 1'b0;
      end
      if (cmd.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/interval_union_coverage_table_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// interval_union_coverage_table_top: table of disjoint closed intervals
// Keeps up to MAX_INTERVALS disjoint intervals; adds merge, queries check
// containment, one result beat per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : in_valid/in_ready with func, range_low, range_high
//   output channel : out_valid/out_ready with covered, table_full
//   in_ready is high only while the sequencer is idle; one item is in work
//   at a time. Every nonempty item walks the table through one compare unit
//   and the single read port of the endpoint memory, one entry per cycle.
//   Query, or add that is already contained or dropped: one scan pass, then
//   the result. Add that stores a new entry: a second merge pass plus a
//   write. An empty (reversed) interval skips the table and goes straight to
//   the result. The next item can be accepted in the same cycle that
//   out_valid rises, since the sequencer is then idle again.
//   The result sits in an output register, so the next item may be accepted
//   while it waits; if the receiver still stalls when that item finishes,
//   the sequencer holds until the output register frees up.
//   Reset empties the table at once (valid bits cleared, count zeroed); no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module interval_union_coverage_table_top #(
  parameter int MAX_INTERVALS = iuct_pkg::MAX_INTERVALS_DEF,
  parameter int COORD_BITS    = iuct_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            func,
  input  logic [iuct_pkg::FIELD_BITS-1:0] range_low,
  input  logic [iuct_pkg::FIELD_BITS-1:0] range_high,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            covered,
  output logic                            table_full
);

  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_INTERVALS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_INTERVALS - 1);

  iuct_pkg::state_t state, state_next;
  iuct_pkg::func_t  op;

  logic [COORD_BITS-1:0] item_low, item_high;
  logic [COORD_BITS-1:0] acc_low, acc_low_next, acc_high, acc_high_next;
  logic [COORD_BITS-1:0] lo_in, hi_in;
  logic [CNT_W-1:0]      rd_idx, rd_idx_next;
  logic [CNT_W-1:0]      entry_count, entry_count_next;
  logic [IDX_W-1:0]      pend_idx, pend_idx_next;
  logic [IDX_W-1:0]      free_idx, free_idx_next;
  logic                  pend, pend_next;
  logic                  hit, hit_next, ovl, ovl_next;
  logic                  free_found, free_found_next;
  logic                  res_covered, res_covered_next;
  logic                  res_full, res_full_next;

  logic                  accept, issue, last, slot_free;
  logic                  cur_contain, cur_ovl, hit_all, ovl_all;

  iuct_pkg::store_cmd_t  cmd;
  iuct_pkg::cmp_res_t    res;
  logic [COORD_BITS-1:0] rd_low, rd_high, merge_low, merge_high;
  logic                  rd_valid;

  assign lo_in     = COORD_BITS'(range_low);
  assign hi_in     = COORD_BITS'(range_high);
  assign in_ready  = (state == iuct_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // read one entry per cycle while a pass is running
  assign issue = ((state == iuct_pkg::ST_SCAN) || (state == iuct_pkg::ST_MERGE))
                 && (rd_idx != CNT_MAX);
  assign last  = pend && (pend_idx == LAST_IDX);

  assign cur_contain = pend && rd_valid && res.contain;
  assign cur_ovl     = pend && rd_valid && res.overlap;
  assign hit_all     = hit || cur_contain;
  assign ovl_all     = ovl || cur_ovl;

  assign cmd.rd_en  = issue;
  assign cmd.wr_en  = (state == iuct_pkg::ST_WRITE);
  assign cmd.clr_en = (state == iuct_pkg::ST_MERGE) && cur_ovl;

  iuct_store #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .COORD_BITS    (COORD_BITS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rd_addr  (rd_idx[IDX_W-1:0]),
    .rd_low   (rd_low),
    .rd_high  (rd_high),
    .rd_valid (rd_valid),
    .wr_addr  (free_idx),
    .wr_low   (acc_low),
    .wr_high  (acc_high),
    .clr_addr (pend_idx)
  );

  iuct_cmp #(
    .COORD_BITS (COORD_BITS)
  ) u_cmp (
    .item_low   (item_low),
    .item_high  (item_high),
    .entry_low  (rd_low),
    .entry_high (rd_high),
    .acc_low    (acc_low),
    .acc_high   (acc_high),
    .res        (res),
    .merge_low  (merge_low),
    .merge_high (merge_high)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iuct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    rd_idx_next      = issue ? rd_idx + CNT_W'(1) : rd_idx;
    pend_next        = issue;
    pend_idx_next    = rd_idx[IDX_W-1:0];
    hit_next         = hit;
    ovl_next         = ovl;
    acc_low_next     = acc_low;
    acc_high_next    = acc_high;
    free_found_next  = free_found;
    free_idx_next    = free_idx;
    entry_count_next = entry_count;
    res_covered_next = res_covered;
    res_full_next    = res_full;

    unique case (state)
      iuct_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_covered_next = 1'b0;
          res_full_next    = 1'b0;
          hit_next         = 1'b0;
          ovl_next         = 1'b0;
          rd_idx_next      = '0;
          // an empty interval touches nothing
          if (lo_in > hi_in) begin
            state_next = iuct_pkg::ST_RESULT;
          end else begin
            state_next = iuct_pkg::ST_SCAN;
          end
        end
      end

      iuct_pkg::ST_SCAN: begin
        hit_next = hit_all;
        ovl_next = ovl_all;
        if (last) begin
          if (op == iuct_pkg::FUNC_QUERY) begin
            res_covered_next = hit_all;
            state_next       = iuct_pkg::ST_RESULT;
          end else if (hit_all) begin
            state_next = iuct_pkg::ST_RESULT;
          end else if ((entry_count == CNT_MAX) && !ovl_all) begin
            res_full_next = 1'b1;
            state_next    = iuct_pkg::ST_RESULT;
          end else begin
            rd_idx_next     = '0;
            acc_low_next    = item_low;
            acc_high_next   = item_high;
            free_found_next = 1'b0;
            state_next      = iuct_pkg::ST_MERGE;
          end
        end
      end

      iuct_pkg::ST_MERGE: begin
        if (cur_ovl) begin
          acc_low_next     = merge_low;
          acc_high_next    = merge_high;
          entry_count_next = entry_count - CNT_W'(1);
        end
        // lowest slot that is free once absorbed entries are gone
        if (pend && !free_found && (!rd_valid || cur_ovl)) begin
          free_found_next = 1'b1;
          free_idx_next   = pend_idx;
        end
        if (last) begin
          state_next = iuct_pkg::ST_WRITE;
        end
      end

      iuct_pkg::ST_WRITE: begin
        entry_count_next = entry_count + CNT_W'(1);
        state_next       = iuct_pkg::ST_RESULT;
      end

      iuct_pkg::ST_RESULT: begin
        if (slot_free) begin
          state_next = iuct_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = iuct_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx      <= '0;
      pend        <= 1'b0;
      hit         <= 1'b0;
      ovl         <= 1'b0;
      free_found  <= 1'b0;
      entry_count <= '0;
    end else begin
      rd_idx      <= rd_idx_next;
      pend        <= pend_next;
      hit         <= hit_next;
      ovl         <= ovl_next;
      free_found  <= free_found_next;
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx    <= pend_idx_next;
    free_idx    <= free_idx_next;
    acc_low     <= acc_low_next;
    acc_high    <= acc_high_next;
    res_covered <= res_covered_next;
    res_full    <= res_full_next;
    if (accept) begin
      op        <= iuct_pkg::func_t'(func);
      item_low  <= lo_in;
      item_high <= hi_in;
    end
  end

  // output register, loaded only when the previous beat has left
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == iuct_pkg::ST_RESULT) && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == iuct_pkg::ST_RESULT) && slot_free) begin
      covered    <= res_covered;
      table_full <= res_full;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_MAX)
    else $error("entry count above table size");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (state == iuct_pkg::ST_RESULT) && slot_free && res_full |-> entry_count == CNT_MAX)
    else $error("add dropped while table had room");

  a_write_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> free_found)
    else $error("table write without a free slot");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("ready stayed high after accepting an item");
`endif

endmodule
`default_nettype wire
